### src/ist_pkg.sv
// package: types, constants and state codes for the interval set table
package ist_pkg;
  localparam int MaxIntervals = 16;
  localparam int IdxW = $clog2(MaxIntervals);
  localparam int CntW = $clog2(MaxIntervals + 1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_CONTAINS = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] func;
    logic signed [31:0] range_start;
    logic signed [31:0] range_end;
  } in_beat_t;

  typedef struct packed {
    logic ok;
    logic [1:0] status;
    logic [4:0] entry_count;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INSERT,
    SH_DELETE
  } shift_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic decide;
    logic shift_step;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic immediate;
  } sts_t;
endpackage

### src/interval_set_table_top.sv
// top level: sorted disjoint interval table with merge
// clear, invalid range or unused code go straight from idle to the result state;
// otherwise the beat passes through the scan, decide and shift states before the result
// one beat in flight at a time; the rate is set by the single-entry scan and shift walk
// synchronous active-low reset empties the table; entry storage is not cleared
module interval_set_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ist_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ist_pkg::out_beat_t out_data
);
  import ist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ist_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  ist_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_beat(in_data), .cmd(cmd), .sts(sts), .res(out_data)
  );
endmodule

### src/ist_datapath.sv
// datapath: interval storage, scan compare, insert and delete shifting
module ist_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ist_pkg::in_beat_t  in_beat,
  input  ist_pkg::cmd_t      cmd,
  output ist_pkg::sts_t      sts,
  output ist_pkg::out_beat_t res
);
  import ist_pkg::*;

  logic signed [31:0] starts_r [MaxIntervals];
  logic signed [31:0] ends_r [MaxIntervals];
  logic [CntW-1:0] count_r, count_nxt;
  logic [1:0] func_r;
  logic signed [31:0] s_r, e_r;
  logic [CntW-1:0] i_r, i_nxt, p_r, p_nxt;
  logic ovl_r, ovl_nxt, cov_r, cov_nxt;
  logic ok_r, ok_nxt;
  logic [1:0] st_r, st_nxt;
  shift_t sh_r, sh_nxt;
  logic signed [31:0] eprev_r, snext_r, enext_r;
  logic signed [31:0] cs, ce;
  logic [IdxW-1:0] iidx;
  logic left, right;
  logic [IdxW-1:0] pidx, pm1;

  assign iidx = i_r[IdxW-1:0];
  assign cs = starts_r[iidx];
  assign ce = ends_r[iidx];
  assign pidx = p_r[IdxW-1:0];
  assign pm1 = pidx - 1'b1;

  assign sts.scan_done = (i_r >= count_r) ||
    (func_r == FUNC_ADD && ovl_r) || (func_r == FUNC_CONTAINS && cov_r);
  assign sts.shift_done = (sh_r == SH_INSERT) ? (i_r <= p_r) :
    (sh_r == SH_DELETE) ? (i_r + 1'b1 >= count_r) : 1'b1;
  assign sts.immediate = (in_beat.func == FUNC_CLEAR) || (in_beat.func == FUNC_NONE) ||
    (in_beat.range_start >= in_beat.range_end);

  assign left = (p_r != '0) && (eprev_r == s_r);
  assign right = (p_r < count_r) && (snext_r == e_r);

  always_comb begin
    i_nxt = i_r;
    p_nxt = p_r;
    ovl_nxt = ovl_r;
    cov_nxt = cov_r;
    ok_nxt = ok_r;
    st_nxt = st_r;
    sh_nxt = sh_r;
    count_nxt = count_r;
    if (cmd.load) begin
      i_nxt = '0;
      p_nxt = '0;
      ovl_nxt = 1'b0;
      cov_nxt = 1'b0;
      sh_nxt = SH_NONE;
      ok_nxt = 1'b0;
      st_nxt = ST_INVALID;
      if (in_beat.func == FUNC_CLEAR) begin
        ok_nxt = 1'b1;
        st_nxt = ST_DONE;
        count_nxt = '0;
      end
    end
    if (cmd.scan_step && !sts.scan_done) begin
      if (s_r < ce && cs < e_r) ovl_nxt = 1'b1;
      if (cs <= s_r && ce >= e_r) cov_nxt = 1'b1;
      if (ce <= s_r) p_nxt = i_r + 1'b1;
      i_nxt = i_r + 1'b1;
    end
    if (cmd.decide) begin
      ok_nxt = 1'b1;
      st_nxt = ST_DONE;
      if (func_r == FUNC_CONTAINS) begin
        if (!cov_r) begin
          ok_nxt = 1'b0;
          st_nxt = ST_MISS;
        end
      end else if (ovl_r) begin
        ok_nxt = 1'b0;
        st_nxt = ST_MISS;
      end else if (left && right) begin
        sh_nxt = SH_DELETE;
        i_nxt = p_r;
      end else if (!left && !right) begin
        if (count_r >= CntW'(MaxIntervals)) begin
          ok_nxt = 1'b0;
          st_nxt = ST_FULL;
        end else begin
          sh_nxt = SH_INSERT;
          i_nxt = count_r;
        end
      end
    end
    if (cmd.shift_step && !sts.shift_done) begin
      if (sh_r == SH_INSERT) i_nxt = i_r - 1'b1;
      else i_nxt = i_r + 1'b1;
    end
    if (cmd.shift_step && sts.shift_done) begin
      if (sh_r == SH_INSERT) count_nxt = count_r + 1'b1;
      else if (sh_r == SH_DELETE) count_nxt = count_r - 1'b1;
      sh_nxt = SH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    i_r <= i_nxt;
    p_r <= p_nxt;
    ovl_r <= ovl_nxt;
    cov_r <= cov_nxt;
    ok_r <= ok_nxt;
    st_r <= st_nxt;
    sh_r <= sh_nxt;
    if (cmd.load) begin
      func_r <= in_beat.func;
      s_r <= in_beat.range_start;
      e_r <= in_beat.range_end;
    end
    // neighbor entries for the merge decision
    if (cmd.scan_step && sts.scan_done) begin
      eprev_r <= ends_r[pm1];
      snext_r <= starts_r[pidx];
      enext_r <= ends_r[pidx];
    end
    if (cmd.decide && func_r == FUNC_ADD && !ovl_r) begin
      if (left && right) ends_r[pm1] <= enext_r;
      else if (left) ends_r[pm1] <= e_r;
      else if (right) starts_r[pidx] <= s_r;
    end
    if (cmd.shift_step) begin
      if (sh_r == SH_INSERT) begin
        if (!sts.shift_done) begin
          starts_r[iidx] <= starts_r[iidx - 1'b1];
          ends_r[iidx] <= ends_r[iidx - 1'b1];
        end else begin
          starts_r[pidx] <= s_r;
          ends_r[pidx] <= e_r;
        end
      end else if (sh_r == SH_DELETE && !sts.shift_done) begin
        starts_r[iidx] <= starts_r[iidx + 1'b1];
        ends_r[iidx] <= ends_r[iidx + 1'b1];
      end
    end
  end

  assign res.ok = ok_r;
  assign res.status = st_r;
  assign res.entry_count = 5'(count_r);
endmodule

### src/ist_ctrl.sv
// controller: sequences scan, decide, shift and result hand-off
module ist_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ist_pkg::sts_t  sts,
  output ist_pkg::cmd_t  cmd
);
  import ist_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = sts.immediate ? S_RESULT : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_done) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
